/* hw/rtl/scp_pkg.sv */
`timescale 1ns / 1ps

package scp_pkg;

	localparam int PAYLOAD_MAX_DEF = 1024;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_REFL = 2'd3;

	localparam logic [10:0] MAX_LEN_RST  = 11'd1024;
	localparam logic [31:0] CRC_INIT_RST = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY_RST = 32'h04C1_1DB7;

	localparam logic [7:0] B_END     = 8'hC0;
	localparam logic [7:0] B_ESC     = 8'hDB;
	localparam logic [7:0] B_ESC_END = 8'hDC;
	localparam logic [7:0] B_ESC_ESC = 8'hDD;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_DATA = 3'd1;
	localparam logic [2:0] EV_GOOD = 3'd2;
	localparam logic [2:0] EV_ESC  = 3'd3;
	localparam logic [2:0] EV_LEN  = 3'd4;
	localparam logic [2:0] EV_CRC  = 3'd5;

	typedef struct packed {
		logic       valid;
		logic       end_seen;
		logic       esc_err;
		logic       have;
		logic [7:0] data;
	} dec_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  data_byte;
		logic [9:0]  data_index;
		logic [7:0]  pkt_tag;
		logic [31:0] pkt_id;
		logic [10:0] pkt_len;
		logic [31:0] escape_errors;
		logic [31:0] crc_errors;
	} res_t;

endpackage

/* hw/rtl/scp_if.sv */
`timescale 1ns / 1ps

interface scp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface scp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  data_byte;
	logic [9:0]  data_index;
	logic [7:0]  pkt_tag;
	logic [31:0] pkt_id;
	logic [10:0] pkt_len;
	logic [31:0] escape_errors;
	logic [31:0] crc_errors;

	modport source (output valid, output event_res, output data_byte, output data_index,
		output pkt_tag, output pkt_id, output pkt_len, output escape_errors,
		output crc_errors, input ready);
	modport sink (input valid, input event_res, input data_byte, input data_index,
		input pkt_tag, input pkt_id, input pkt_len, input escape_errors,
		input crc_errors, output ready);
endinterface

/* hw/rtl/scp_unstuff.sv */
`timescale 1ns / 1ps

module scp_unstuff
	import scp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	output logic       in_ready,
	input  logic       take,
	output dec_t       dec
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       esc_pending_q;
	logic       adv;

	assign in_ready = !valid_s1 || take;
	assign adv      = valid_s1 && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				byte_s1 <= in_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pending_q <= 1'b0;
		end else if (adv) begin
			if (byte_s1 == B_END || esc_pending_q) begin
				esc_pending_q <= 1'b0;
			end else if (byte_s1 == B_ESC) begin
				esc_pending_q <= 1'b1;
			end
		end
	end

	// END always wins, even right after ESC
	always_comb begin
		dec          = '0;
		dec.valid    = valid_s1;
		dec.data     = byte_s1;
		if (byte_s1 == B_END) begin
			dec.end_seen = 1'b1;
		end else if (esc_pending_q) begin
			if (byte_s1 == B_ESC_END) begin
				dec.data = B_END;
				dec.have = 1'b1;
			end else if (byte_s1 == B_ESC_ESC) begin
				dec.data = B_ESC;
				dec.have = 1'b1;
			end else begin
				dec.esc_err = 1'b1;
			end
		end else if (byte_s1 != B_ESC) begin
			dec.have = 1'b1;
		end
	end

endmodule

/* hw/rtl/scp_crc8.sv */
`timescale 1ns / 1ps

module scp_crc8
	import scp_pkg::*;
(
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	input  logic [31:0] poly,
	input  logic        reflected,
	output logic [31:0] crc_out
);

	logic [31:0] rpoly;
	logic [31:0] c;

	assign rpoly = {<<{poly}};

	// eight bit steps of the serial divider, one per data bit
	always_comb begin
		if (reflected) begin
			c = crc_in ^ {24'd0, data};
			for (int i = 0; i < 8; i++) begin
				c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
			end
		end else begin
			c = crc_in ^ {data, 24'd0};
			for (int i = 0; i < 8; i++) begin
				c = c[31] ? ((c << 1) ^ poly) : (c << 1);
			end
		end
		crc_out = c;
	end

endmodule

/* hw/rtl/scp_parser.sv */
`timescale 1ns / 1ps

module scp_parser
	import scp_pkg::*;
#(
	parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dec_t        dec,
	output logic        take,
	input  logic [10:0] max_len,
	input  logic [31:0] crc_init,
	input  logic [31:0] crc_poly,
	input  logic        crc_refl,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	localparam logic [3:0] PH_ERROR = 4'd0;
	localparam logic [3:0] PH_TAG   = 4'd1;
	localparam logic [3:0] PH_ID0   = 4'd2;
	localparam logic [3:0] PH_ID1   = 4'd3;
	localparam logic [3:0] PH_ID2   = 4'd4;
	localparam logic [3:0] PH_ID3   = 4'd5;
	localparam logic [3:0] PH_LEN0  = 4'd6;
	localparam logic [3:0] PH_LEN1  = 4'd7;
	localparam logic [3:0] PH_DATA  = 4'd8;
	localparam logic [3:0] PH_CRC0  = 4'd9;
	localparam logic [3:0] PH_CRC1  = 4'd10;
	localparam logic [3:0] PH_CRC2  = 4'd11;
	localparam logic [3:0] PH_CRC3  = 4'd12;
	localparam logic [3:0] PH_DONE  = 4'd13;

	localparam logic [15:0] PMAX = 16'(PAYLOAD_MAX);

	logic [3:0]  phase_q, phase_n;
	logic [31:0] crc_q, crc_n;
	logic [7:0]  tag_q, tag_n;
	logic [31:0] id_q, id_n;
	logic [15:0] len_q, len_n;
	logic [10:0] cnt_q, cnt_n;
	logic [23:0] rcrc_q, rcrc_n;
	logic [31:0] esc_cnt_q, esc_cnt_n;
	logic [31:0] crc_cnt_q, crc_cnt_n;
	logic [31:0] crc_seed, crc_upd;
	logic [15:0] limit, len_full;
	logic [10:0] cnt_inc;
	logic        adv;
	res_t        r;

	assign take = !res_valid || res_ready;
	assign adv  = dec.valid && take;

	assign crc_seed = (phase_q == PH_TAG) ? crc_init : crc_q;

	scp_crc8 u_crc (
		.crc_in    (crc_seed),
		.data      (dec.data),
		.poly      (crc_poly),
		.reflected (crc_refl),
		.crc_out   (crc_upd)
	);

	assign limit    = ({5'd0, max_len} > PMAX) ? PMAX : {5'd0, max_len};
	assign len_full = {dec.data, len_q[7:0]};
	assign cnt_inc  = cnt_q + 11'd1;

	always_comb begin
		phase_n   = phase_q;
		crc_n     = crc_q;
		tag_n     = tag_q;
		id_n      = id_q;
		len_n     = len_q;
		cnt_n     = cnt_q;
		rcrc_n    = rcrc_q;
		esc_cnt_n = esc_cnt_q;
		crc_cnt_n = crc_cnt_q;
		r         = '0;
		r.event_res = EV_NONE;
		if (dec.end_seen) begin
			phase_n = PH_TAG;
		end else if (dec.esc_err) begin
			phase_n     = PH_ERROR;
			esc_cnt_n   = esc_cnt_q + 32'd1;
			r.event_res = EV_ESC;
		end else if (dec.have) begin
			case (phase_q)
				PH_TAG: begin
					crc_n   = crc_upd;
					tag_n   = dec.data;
					phase_n = PH_ID0;
				end
				PH_ID0: begin
					crc_n   = crc_upd;
					id_n    = {24'd0, dec.data};
					phase_n = PH_ID1;
				end
				PH_ID1: begin
					crc_n   = crc_upd;
					id_n    = {id_q[31:16], dec.data, id_q[7:0]};
					phase_n = PH_ID2;
				end
				PH_ID2: begin
					crc_n   = crc_upd;
					id_n    = {id_q[31:24], dec.data, id_q[15:0]};
					phase_n = PH_ID3;
				end
				PH_ID3: begin
					crc_n   = crc_upd;
					id_n    = {dec.data, id_q[23:0]};
					phase_n = PH_LEN0;
				end
				PH_LEN0: begin
					crc_n   = crc_upd;
					len_n   = {8'd0, dec.data};
					phase_n = PH_LEN1;
				end
				PH_LEN1: begin
					crc_n = crc_upd;
					len_n = len_full;
					if (len_full > limit) begin
						phase_n     = PH_ERROR;
						r.event_res = EV_LEN;
					end else if (len_full == 16'd0) begin
						phase_n = PH_CRC0;
					end else begin
						cnt_n   = '0;
						phase_n = PH_DATA;
					end
				end
				PH_DATA: begin
					crc_n        = crc_upd;
					r.event_res  = EV_DATA;
					r.data_byte  = dec.data;
					r.data_index = cnt_q[9:0];
					cnt_n        = cnt_inc;
					if ({5'd0, cnt_inc} >= len_q) begin
						phase_n = PH_CRC0;
					end
				end
				PH_CRC0: begin
					rcrc_n  = {16'd0, dec.data};
					phase_n = PH_CRC1;
				end
				PH_CRC1: begin
					rcrc_n  = {8'd0, dec.data, rcrc_q[7:0]};
					phase_n = PH_CRC2;
				end
				PH_CRC2: begin
					rcrc_n  = {dec.data, rcrc_q[15:0]};
					phase_n = PH_CRC3;
				end
				PH_CRC3: begin
					// received value is compared raw, no final xor
					if ({dec.data, rcrc_q} == crc_q) begin
						phase_n     = PH_DONE;
						r.event_res = EV_GOOD;
						r.pkt_tag   = tag_q;
						r.pkt_id    = id_q;
						r.pkt_len   = len_q[10:0];
					end else begin
						phase_n     = PH_ERROR;
						crc_cnt_n   = crc_cnt_q + 32'd1;
						r.event_res = EV_CRC;
					end
				end
				PH_DONE, PH_ERROR: begin
					phase_n = phase_q;
				end
				default: begin
					phase_n = PH_ERROR;
				end
			endcase
		end
		r.escape_errors = esc_cnt_n;
		r.crc_errors    = crc_cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ERROR;
			crc_q     <= '0;
			tag_q     <= '0;
			id_q      <= '0;
			len_q     <= '0;
			cnt_q     <= '0;
			rcrc_q    <= '0;
			esc_cnt_q <= '0;
			crc_cnt_q <= '0;
		end else if (adv) begin
			phase_q   <= phase_n;
			crc_q     <= crc_n;
			tag_q     <= tag_n;
			id_q      <= id_n;
			len_q     <= len_n;
			cnt_q     <= cnt_n;
			rcrc_q    <= rcrc_n;
			esc_cnt_q <= esc_cnt_n;
			crc_cnt_q <= crc_cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
			res       <= '0;
		end else if (adv) begin
			res_valid <= 1'b1;
			res       <= r;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

endmodule

/* hw/rtl/slip_crc_packet_receiver.sv */
`timescale 1ns / 1ps

// channel   dir   modport   word
// rx        in    sink      one raw line byte, rx_byte
// res       out   source    one result per byte: event and packet fields, error counts
// cfg       in    -         cfg_we / cfg_idx / cfg_data, write only
//
// one byte per cycle sustained while res.ready is high; an accepted rx byte passes
// the input stage, then unstuff + parse + byte-wide crc update into the result register
// arst_n clears the parser to the error phase: bytes are dropped until an END
// a stall on res backs up through the input stage; nothing is lost or repeated

module slip_crc_packet_receiver
	import scp_pkg::*;
#(
	parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	scp_byte_if.sink              rx,
	scp_res_if.source             res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [10:0] max_len_q;
	logic [31:0] crc_init_q;
	logic [31:0] crc_poly_q;
	logic        crc_refl_q;
	logic        take;
	logic        res_valid;
	dec_t        dec;
	res_t        res_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q  <= MAX_LEN_RST;
			crc_init_q <= CRC_INIT_RST;
			crc_poly_q <= CRC_POLY_RST;
			crc_refl_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_LEN:  max_len_q  <= cfg_data[10:0];
				REG_CRC_INIT: crc_init_q <= cfg_data;
				REG_CRC_POLY: crc_poly_q <= cfg_data;
				REG_CRC_REFL: crc_refl_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	scp_unstuff u_unstuff (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_byte  (rx.rx_byte),
		.in_ready (rx.ready),
		.take     (take),
		.dec      (dec)
	);

	scp_parser #(
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec       (dec),
		.take      (take),
		.max_len   (max_len_q),
		.crc_init  (crc_init_q),
		.crc_poly  (crc_poly_q),
		.crc_refl  (crc_refl_q),
		.res_valid (res_valid),
		.res_ready (res.ready),
		.res       (res_w)
	);

	assign res.valid         = res_valid;
	assign res.event_res     = res_w.event_res;
	assign res.data_byte     = res_w.data_byte;
	assign res.data_index    = res_w.data_index;
	assign res.pkt_tag       = res_w.pkt_tag;
	assign res.pkt_id        = res_w.pkt_id;
	assign res.pkt_len       = res_w.pkt_len;
	assign res.escape_errors = res_w.escape_errors;
	assign res.crc_errors    = res_w.crc_errors;

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.event_res <= EV_CRC)
		else $error("event code out of range");

	a_data_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.event_res != EV_DATA) |->
			(res.data_byte == 8'd0 && res.data_index == 10'd0))
		else $error("payload fields set on a non-data word");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		(dec.valid && !take) |=> (dec.valid && $stable(dec)))
		else $error("input stage lost a byte while stalled");

	a_good_len: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.event_res == EV_GOOD) |-> res.pkt_len <= max_len_q)
		else $error("good packet longer than the limit");

endmodule
